### hw/rtl/dpwt_pkg.sv
package dpwt_pkg;

    localparam int unsigned PAGE_W = 36;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned LIM_W  = 17;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned STAT_W = 3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ROUND = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVER  = 3'd1;
    localparam logic [STAT_W-1:0] ST_SAVED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO  = 3'd4;
    localparam logic [STAT_W-1:0] ST_ROUND = 3'd5;

    localparam logic [0:0] REG_SCAN_LIMIT = 1'd0;
    localparam logic [0:0] REG_SAVE_LIMIT = 1'd1;

    localparam logic [LIM_W-1:0] SCAN_LIMIT_RST = 17'd1025;
    localparam logic [LIM_W-1:0] SAVE_LIMIT_RST = 17'd257;

    // dividend 66 bits (32*17*17), divisor 35 bits (17*17*2)
    localparam int unsigned DVD_W = 66;
    localparam int unsigned DVS_W = 35;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } t_div_rsp;

endpackage

### hw/rtl/dirty_page_writeback_tracker_unit.sv
// Dirty page write-back tracker.
// Items arrive on the s_axis channel: tdata = {prev_tick, cur_tick, page_number},
// tuser = op. Each item yields one result beat on m_axis: tdata =
// {current_threshold, saved_so_far, dirty_count}, tuser = status.
// Writes and scans probe the table one slot at a time, each probe a registered
// memory read (S_RD) and then a check (S_CHK), up to PROBE_LIMIT slots. A scan
// first runs the serial divider, one quotient bit a cycle, and waits for its
// quotient before the probe. A round op does not probe the table.
// One item is in flight at a time; s_axis_tready is low while it is worked on
// and while its result waits in S_OUT behind a stalled beat. A stalled result holds.
// After reset the table is cleared by a pass over all TABLE_ENTRIES slots, one
// slot a cycle, during which no item is accepted; APB writes are taken as ever.
// Limits: scan_limit at 0x0, save_limit at 0x4.
module dirty_page_writeback_tracker_unit #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    parameter int unsigned PROBE_LIMIT   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // page_number[35:0], cur_tick[67:36], prev_tick[99:68], zero fill
    input  logic [103:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dirty_count[15:0], saved_so_far[32:16], current_threshold[64:33], zero fill
    output logic [71:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);
    localparam int unsigned PAGE_W = dpwt_pkg::PAGE_W;
    localparam int unsigned TIME_W = dpwt_pkg::TIME_W;
    localparam int unsigned LIM_W  = dpwt_pkg::LIM_W;
    localparam int unsigned CNT_W  = dpwt_pkg::CNT_W;
    // entry: key, dirty, aged, stamp
    localparam int unsigned EW = PAGE_W + 2 + TIME_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_DIV, S_DIVW, S_RD, S_CHK, S_OUT
    } t_state;

    t_state r_state;
    logic [LIM_W-1:0] r_scan_limit, r_save_limit;
    logic [1:0]        r_op;
    logic [PAGE_W-1:0] r_page;
    logic [TIME_W-1:0] r_now, r_last;
    logic [TIME_W-1:0] r_age_thr, r_round_thr;
    logic [LIM_W-1:0]  r_scan_cnt, r_save_cnt;
    logic [CNT_W-1:0]  r_dirty_tot;
    logic [AW-1:0]     r_idx;
    logic [PW-1:0]     r_probe;
    logic [dpwt_pkg::STAT_W-1:0] r_status;
    logic [48:0]       r_prod;
    logic [dpwt_pkg::DVD_W-1:0] r_dvd;
    logic [dpwt_pkg::DVS_W-1:0] r_dvs;
    logic              r_div_go;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata, w_rdata;
    logic [PAGE_W-1:0] w_key;
    logic              w_dirty, w_aged;
    logic [TIME_W-1:0] w_stamp;
    logic              w_cfg_wr;
    logic [TIME_W-1:0] w_diff, w_age;
    logic              w_old_now;
    dpwt_pkg::t_div_req w_req;
    dpwt_pkg::t_div_rsp w_rsp;

    assign {w_key, w_dirty, w_aged, w_stamp} = w_rdata;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == dpwt_pkg::REG_SAVE_LIMIT) ?
                      {15'd0, r_save_limit} : {15'd0, r_scan_limit};
    assign w_diff   = r_now - r_last;

    assign w_req.start    = r_div_go;
    assign w_req.dividend = r_dvd;
    assign w_req.divisor  = r_dvs;

    dpwt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    dpwt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_idx), .o_rdata(w_rdata)
    );

    // write-back decision uses threshold just computed
    assign w_age = r_now - r_last;
    // a page stamped later than now is never old enough
    assign w_old_now = (r_now >= r_last) && (w_age >= r_age_thr);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {w_key, w_dirty, w_aged, w_stamp};
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (r_state == S_CHK && w_key == r_page) begin
            if (r_op == dpwt_pkg::OP_WRITE) begin
                w_we    = !w_dirty;
                w_wdata = {r_page, 1'b1, w_aged, w_stamp};
            end else begin
                w_we = w_dirty ||
                       (w_aged && r_now >= w_stamp && (r_now - w_stamp) >= r_age_thr);
                if (w_dirty) begin
                    w_wdata = {r_page, 1'b0, !w_old_now, r_last};
                end else begin
                    w_wdata = {r_page, 1'b0, 1'b0, w_stamp};
                end
            end
        end else if (r_state == S_CHK && w_key == '0 && r_op == dpwt_pkg::OP_WRITE) begin
            w_we    = 1'b1;
            w_wdata = {r_page, 1'b1, 1'b0, w_stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_scan_limit <= dpwt_pkg::SCAN_LIMIT_RST;
            r_save_limit <= dpwt_pkg::SAVE_LIMIT_RST;
            r_age_thr    <= '0;
            r_round_thr  <= '0;
            r_scan_cnt   <= LIM_W'(1);
            r_save_cnt   <= LIM_W'(1);
            r_dirty_tot  <= '0;
            r_div_go     <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (w_cfg_wr) begin
                if (paddr[2] == dpwt_pkg::REG_SCAN_LIMIT) r_scan_limit <= pwdata[LIM_W-1:0];
                else r_save_limit <= pwdata[LIM_W-1:0];
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(TABLE_ENTRIES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_page   <= s_axis_tdata[35:0];
                        r_now    <= s_axis_tdata[67:36];
                        r_last   <= s_axis_tdata[99:68];
                        r_idx    <= s_axis_tdata[AW-1:0];
                        r_probe  <= '0;
                        r_status <= dpwt_pkg::ST_DONE;
                        r_state  <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_OUT;
                    unique case (r_op)
                        dpwt_pkg::OP_WRITE: begin
                            if (r_page == '0) r_status <= dpwt_pkg::ST_ZERO;
                            else r_state <= S_RD;
                        end
                        dpwt_pkg::OP_ROUND: begin
                            if (r_now > r_last && w_diff > r_age_thr) begin
                                r_age_thr   <= w_diff;
                                r_round_thr <= w_diff;
                            end else begin
                                r_round_thr <= r_age_thr;
                            end
                            r_scan_cnt <= LIM_W'(1);
                            r_save_cnt <= LIM_W'(1);
                            r_status   <= dpwt_pkg::ST_ROUND;
                        end
                        dpwt_pkg::OP_SCAN: begin
                            if (r_scan_cnt >= r_scan_limit || r_save_cnt >= r_save_limit)
                                r_status <= dpwt_pkg::ST_OVER;
                            else if (r_page == '0) r_status <= dpwt_pkg::ST_ZERO;
                            else begin
                                r_prod  <= 49'(r_round_thr) * 49'(r_save_cnt);
                                r_dvs   <= {(2*LIM_W)'(r_save_limit) * (2*LIM_W)'(r_scan_cnt),
                                            1'b0};
                                r_state <= S_MUL2;
                            end
                        end
                        default: ;
                    endcase
                end
                S_MUL2: begin
                    r_dvd    <= 66'(r_prod) * 66'(r_scan_limit);
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_rsp.done) begin
                        r_age_thr  <= w_rsp.quotient;
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                        r_state    <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_state <= S_OUT;
                    if (w_key == r_page) begin
                        if (r_op == dpwt_pkg::OP_WRITE) begin
                            if (!w_dirty && !w_aged && r_dirty_tot != '1)
                                r_dirty_tot <= r_dirty_tot + 1'b1;
                        end else if ((w_dirty && w_old_now) ||
                                     (!w_dirty && w_aged && r_now >= w_stamp &&
                                      (r_now - w_stamp) >= r_age_thr)) begin
                            r_save_cnt <= r_save_cnt + 1'b1;
                            if (r_dirty_tot != '0) r_dirty_tot <= r_dirty_tot - 1'b1;
                            r_status <= dpwt_pkg::ST_SAVED;
                        end
                    end else if (w_key == '0) begin
                        if (r_op == dpwt_pkg::OP_WRITE && r_dirty_tot != '1)
                            r_dirty_tot <= r_dirty_tot + 1'b1;
                    end else if (r_probe == PW'(PROBE_LIMIT - 1)) begin
                        if (r_op == dpwt_pkg::OP_WRITE) r_status <= dpwt_pkg::ST_FULL;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_idx   <= r_idx + (r_idx >> 1) + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= r_status;
                        m_axis_tdata  <= {7'd0, r_age_thr, r_save_cnt, r_dirty_tot};
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) m_axis_tvalid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !s_axis_tready)
        else $error("item accepted during clear");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_MUL1)
        else $error("accept did not start item");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> r_probe < PW'(PROBE_LIMIT))
        else $error("probe count overrun");
endmodule

### hw/rtl/dpwt_ram.sv
module dpwt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/dpwt_div.sv
// Restoring divider, one quotient bit a cycle; saturates to all ones.
module dpwt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpwt_pkg::t_div_req i_req,
    output dpwt_pkg::t_div_rsp o_rsp
);
    localparam int unsigned DVD_W = dpwt_pkg::DVD_W;
    localparam int unsigned DVS_W = dpwt_pkg::DVS_W;
    localparam int unsigned CW    = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_num, n_num;
    logic [DVS_W:0]    r_rem, n_rem;
    logic [DVS_W-1:0]  r_den;
    logic [DVD_W-1:0]  r_q, n_q;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W+1:0]  w_shift;

    always_comb begin
        w_shift = {r_rem, r_num[DVD_W-1]};
        n_num   = {r_num[DVD_W-2:0], 1'b0};
        if (w_shift >= {2'b00, r_den}) begin
            n_rem = (DVS_W+1)'(w_shift - {2'b00, r_den});
            n_q   = {r_q[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[DVS_W:0];
            n_q   = {r_q[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // divisor zero gives all ones quotient naturally
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = (|r_q[DVD_W-1:32]) ? '1 : r_q[31:0];
endmodule

### bench/tb_dirty_page_writeback_tracker_unit.sv
module tb_dirty_page_writeback_tracker_unit;
    import dpwt_pkg::*;

    localparam int unsigned SLOTS      = 4096;
    localparam int unsigned PROBES     = 16;
    localparam int unsigned N_PHASES   = 7;
    localparam int unsigned PHASE_ITEMS = 250;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  dirty;
        logic [LIM_W-1:0]  saved;
        logic [TIME_W-1:0] thr;
    } t_result;

    typedef struct {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] last;
        bit                typed;
        t_result           res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    dirty_page_writeback_tracker_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // tracker model state
    logic [PAGE_W-1:0] key_tab   [SLOTS];
    bit                dirty_tab [SLOTS];
    bit                aged_tab  [SLOTS];
    logic [TIME_W-1:0] stamp_tab [SLOTS];
    logic [TIME_W-1:0] age_thr;
    logic [TIME_W-1:0] round_thr;
    int unsigned       scan_cnt;
    int unsigned       save_cnt;
    int unsigned       dirty_cnt;
    int unsigned       scan_lim;
    int unsigned       save_lim;

    t_result     pending_q[$];
    bit          idle_en;
    int unsigned errors = 0;
    int unsigned beats_out = 0;
    int unsigned saves_seen = 0;
    int unsigned fulls_seen = 0;
    int unsigned overs_seen = 0;
    int unsigned cycles = 0;
    int unsigned rx_hold = 0;
    logic [PAGE_W-1:0] page_pool[48];
    logic [TIME_W-1:0] tick;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // 0: no room, 1: key found, 2: empty slot
    function automatic int find_slot(input logic [PAGE_W-1:0] page, output int unsigned slot);
        int unsigned idx;
        idx = 32'(page[$clog2(SLOTS)-1:0]);
        for (int k = 0; k < PROBES; k++) begin
            if (key_tab[idx] == page) begin
                slot = idx;
                return 1;
            end
            if (key_tab[idx] == '0) begin
                slot = idx;
                return 2;
            end
            idx = (idx + (idx >> 1) + 1) & (SLOTS - 1);
        end
        slot = 0;
        return 0;
    endfunction

    function automatic logic [TIME_W-1:0] scaled_threshold();
        logic [DVD_W-1:0] num;
        logic [DVD_W-1:0] den;
        logic [DVD_W-1:0] quo;
        num = DVD_W'(round_thr) * DVD_W'(save_cnt) * DVD_W'(scan_lim);
        den = DVD_W'(save_lim) * DVD_W'(scan_cnt) * 2;
        if (den == 0) return '1;
        quo = num / den;
        return (quo[DVD_W-1:TIME_W] != 0) ? '1 : quo[TIME_W-1:0];
    endfunction

    function automatic t_result track_item(input logic [1:0] op, input logic [PAGE_W-1:0] page,
                                           input logic [TIME_W-1:0] now,
                                           input logic [TIME_W-1:0] last);
        t_result r;
        int unsigned slot;
        int hit;
        r.status = ST_DONE;
        if (op == OP_WRITE) begin
            if (page == '0) begin
                r.status = ST_ZERO;
            end else begin
                hit = find_slot(page, slot);
                if (hit == 0) begin
                    r.status = ST_FULL;
                end else begin
                    key_tab[slot] = page;
                    if (!dirty_tab[slot]) begin
                        dirty_tab[slot] = 1'b1;
                        if (!aged_tab[slot] && dirty_cnt < 65535) dirty_cnt++;
                    end
                end
            end
        end else if (op == OP_ROUND) begin
            if (now > last && (now - last) > age_thr) age_thr = now - last;
            round_thr = age_thr;
            scan_cnt = 1;
            save_cnt = 1;
            r.status = ST_ROUND;
        end else if (op == OP_SCAN) begin
            if (scan_cnt >= scan_lim || save_cnt >= save_lim) begin
                r.status = ST_OVER;
            end else if (page == '0) begin
                r.status = ST_ZERO;
            end else begin
                age_thr = scaled_threshold();
                scan_cnt++;
                if (find_slot(page, slot) == 1) begin
                    if (dirty_tab[slot]) begin
                        aged_tab[slot] = 1'b1;
                        dirty_tab[slot] = 1'b0;
                        stamp_tab[slot] = last;
                    end
                    if (aged_tab[slot] && now >= stamp_tab[slot] &&
                        (now - stamp_tab[slot]) >= age_thr) begin
                        aged_tab[slot] = 1'b0;
                        save_cnt++;
                        if (dirty_cnt > 0) dirty_cnt--;
                        r.status = ST_SAVED;
                    end
                end
            end
        end
        r.dirty = dirty_cnt[CNT_W-1:0];
        r.saved = save_cnt[LIM_W-1:0];
        r.thr   = age_thr;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [PAGE_W-1:0] page,
                             input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] last,
                             input bit typed, input t_result typed_res);
        t_result r;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, last, now, page};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        r = track_item(op, page, now, last);
        pending_q.push_back(typed ? typed_res : r);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(REG_SCAN_LIMIT) * 4) scan_lim = data & 32'h1FFFF;
        else save_lim = data & 32'h1FFFF;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // result side: check and random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result want;
            t_result got;
            got.status = m_axis_tuser;
            got.dirty  = m_axis_tdata[15:0];
            got.saved  = m_axis_tdata[32:16];
            got.thr    = m_axis_tdata[64:33];
            beats_out++;
            if (got.status == ST_SAVED) saves_seen++;
            if (got.status == ST_FULL) fulls_seen++;
            if (got.status == ST_OVER) overs_seen++;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.dirty !== want.dirty) begin
                    $error("dirty_count: expected %0d got %0d", want.dirty, got.dirty);
                    errors++;
                end
                if (got.saved !== want.saved) begin
                    $error("saved_so_far: expected %0d got %0d", want.saved, got.saved);
                    errors++;
                end
                if (got.thr !== want.thr) begin
                    $error("current_threshold: expected %0d got %0d", want.thr, got.thr);
                    errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("dirty_page_writeback_tracker_unit test failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_result none;
        int unsigned scan_set[N_PHASES];
        int unsigned save_set[N_PHASES];
        logic [1:0] op;
        logic [PAGE_W-1:0] page;
        logic [TIME_W-1:0] delta;
        int unsigned pick;

        scan_set = '{1025, 65536, 2, 40, 5, 65536, 300};
        save_set = '{257, 65536, 2, 12, 65536, 2, 60};
        none = '0;
        idle_en = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_WRITE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        foreach (key_tab[i]) begin
            key_tab[i] = '0;
            dirty_tab[i] = 1'b0;
            aged_tab[i] = 1'b0;
            stamp_tab[i] = '0;
        end
        age_thr = '0;
        round_thr = '0;
        scan_cnt = 1;
        save_cnt = 1;
        dirty_cnt = 0;
        scan_lim = SCAN_LIMIT_RST;
        save_lim = SAVE_LIMIT_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset limits
        rows.push_back('{OP_WRITE, '0, 32'd7, 32'd3, 1, '{ST_ZERO, 16'd0, 17'd1, 32'd0}});
        rows.push_back('{OP_WRITE, '1, 32'd0, 32'd0, 1, '{ST_DONE, 16'd1, 17'd1, 32'd0}});
        rows.push_back('{OP_WRITE, 36'd1, '1, '1, 1, '{ST_DONE, 16'd2, 17'd1, 32'd0}});
        rows.push_back('{OP_WRITE, 36'd1, 32'd0, 32'd0, 1, '{ST_DONE, 16'd2, 17'd1, 32'd0}});
        rows.push_back('{OP_ROUND, 36'd5, 32'd100, 32'd40, 1, '{ST_ROUND, 16'd2, 17'd1, 32'd60}});
        // time going backwards leaves the threshold alone
        rows.push_back('{OP_ROUND, '1, 32'd5, 32'd10, 1, '{ST_ROUND, 16'd2, 17'd1, 32'd60}});
        rows.push_back('{OP_SCAN, '0, 32'd9, 32'd1, 1, '{ST_ZERO, 16'd2, 17'd1, 32'd60}});
        rows.push_back('{OP_SCAN, 36'd1, 32'd1000, 32'd900, 0, none});
        rows.push_back('{OP_SCAN, 36'd1, 32'd1000, 32'd900, 0, none});
        rows.push_back('{OP_SCAN, 36'd2, 32'd1000, 32'd900, 0, none});
        rows.push_back('{OP_SCAN, '1, '1, 32'd0, 0, none});
        rows.push_back('{OP_SCAN, '1, 32'd0, '1, 0, none});
        rows.push_back('{2'd3, 36'h5A5A5A5A5, '1, '1, 0, none});
        // one probe chain overfilled: the last write finds no room
        for (int k = 1; k <= 17; k++)
            rows.push_back('{OP_WRITE, (36'(k) << 12) | 36'h123, 32'd0, 32'd0, 0, none});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.op, row.page, row.now, row.last, row.typed, row.res);
        end
        drain();

        foreach (page_pool[i]) begin
            if (i < 16)
                page_pool[i] = {24'($urandom), 12'h0A5};
            else
                page_pool[i] = {24'($urandom), 12'($urandom_range(0, 7) * 9)};
            if (page_pool[i] == '0) page_pool[i] = 36'h800;
        end
        tick = $urandom;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            apb_write(3'(REG_SCAN_LIMIT) * 4, scan_set[ph]);
            apb_write(3'(REG_SAVE_LIMIT) * 4, save_set[ph]);
            idle_en = (ph != N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                page = page_pool[$urandom_range(0, 47)];
                delta = $urandom_range(0, 40);
                tick = tick + $urandom_range(0, 30);
                if (pick < 40) begin
                    op = OP_WRITE;
                end else if (pick < 48) begin
                    op = OP_ROUND;
                end else if (pick < 94) begin
                    op = OP_SCAN;
                end else begin
                    // noise: any op, any page, any times
                    op = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 2))
                        0: page = '0;
                        1: page = '1;
                        default: page = {4'($urandom), 32'($urandom)};
                    endcase
                    send_item(op, page, $urandom, $urandom, 0, none);
                    continue;
                end
                send_item(op, page, tick, tick - delta, 0, none);
            end
            drain();
        end

        $display("covered %0d result beats over %0d limit settings: %0d write-backs,",
                 beats_out, N_PHASES, saves_seen);
        $display("%0d table-full answers, %0d scans refused at the round limit",
                 fulls_seen, overs_seen);
        if (errors == 0) begin
            $display("dirty_page_writeback_tracker_unit test passed");
        end else begin
            $display("dirty_page_writeback_tracker_unit test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dpwt_pkg.sv
hw/rtl/dpwt_ram.sv
hw/rtl/dpwt_div.sv
hw/rtl/dirty_page_writeback_tracker_unit.sv
bench/tb_dirty_page_writeback_tracker_unit.sv
